// ===== hw/rtl/srmst_pkg.sv =====
package srmst_pkg;

	// Field widths
	localparam int SIZE_W = 7;
	localparam int ROW_W  = 6;
	localparam int COL_W  = 6;
	localparam int VAL_W  = 31;
	localparam int SIDE_W = 7;
	localparam int LVL_W  = 4;

	// Input tdata layout, lowest bit first
	localparam int ROW_LSB  = 0;
	localparam int COL_LSB  = ROW_LSB + ROW_W;
	localparam int VAL_LSB  = COL_LSB + COL_W;
	localparam int SIDE_LSB = VAL_LSB + VAL_W;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	// Request kinds carried on s_tuser
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Exact floor(log2(x)); x = 0 gives 0 and is rejected elsewhere
	function automatic logic [LVL_W-1:0] floor_log2(input logic [SIDE_W-1:0] x);
		logic [LVL_W-1:0] k;
		k = '0;
		for (int b = 1; b < SIDE_W; b++) begin
			if (x[b]) begin
				k = LVL_W'(b);
			end
		end
		return k;
	endfunction

endpackage

// ===== hw/rtl/square_range_max_sparse_table.sv =====
// Loads: taken only while idle. The load of a row's last column (n >= 2) starts
//   a row build that fills levels 1 and up, n - 2^k + 1 entries at level k, each
//   through ST_BA, ST_BB and ST_BW, on the single read port of the table memory.
// Queries: ST_QA, then ST_QB, ST_QC per covered row; out-of-range: only ST_DONE.
// arst_n clears the sequencer, the output valid and sets matrix_size to 64; the
//   table memory is not cleared and holds whatever was loaded before.
module square_range_max_sparse_table #(
	parameter int MAX_SIDE    = 64,
	parameter int LEVEL_COUNT = 7
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write channel: matrix_size
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [srmst_pkg::SIZE_W-1:0]     cfg_data,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// row_index[5:0], col_index[11:6], cell_value[42:12], square_side[49:43]
	input  logic [srmst_pkg::S_TDATA_W-1:0]  s_tdata,
	// req_type[0]
	input  logic [0:0]                       s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// max_value[30:0]
	output logic [srmst_pkg::M_TDATA_W-1:0]  m_tdata,
	// range_error[0]
	output logic [0:0]                       m_tuser
);
	import srmst_pkg::*;

	localparam int CW_RAW = $clog2(MAX_SIDE + 1) + 1;
	localparam int CW     = (CW_RAW > 8) ? CW_RAW : 8;
	localparam int DEPTH  = MAX_SIDE * LEVEL_COUNT * MAX_SIDE;
	localparam int AW     = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BA   = 3'd1;
	localparam logic [2:0] ST_BB   = 3'd2;
	localparam logic [2:0] ST_BW   = 3'd3;
	localparam logic [2:0] ST_QA   = 3'd4;
	localparam logic [2:0] ST_QB   = 3'd5;
	localparam logic [2:0] ST_QC   = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	function automatic logic [AW-1:0] tbl_addr(input logic [CW-1:0] r,
			input logic [LVL_W-1:0] l, input logic [CW-1:0] c);
		return AW'((int'(r) * LEVEL_COUNT + int'(l)) * MAX_SIDE + int'(c));
	endfunction

	logic [2:0]        state_q;
	logic [SIZE_W-1:0] size_q;
	logic              m_tvalid_q;
	logic [VAL_W-1:0]  m_val_q;
	logic              m_err_q;

	logic [CW-1:0]     row_q, last_row_q, col_q, colb_q, j_q, len_q, n_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [VAL_W-1:0]  a_q, best_q, rdata_q;
	logic              err_q;

	logic [VAL_W-1:0]  tbl_q [DEPTH];

	// request fields
	logic [CW-1:0]     in_row, in_col, in_side;
	logic [VAL_W-1:0]  in_val;
	logic [LVL_W-1:0]  in_lvl;
	logic [CW-1:0]     n_eff;

	assign in_row  = CW'(s_tdata[ROW_LSB +: ROW_W]);
	assign in_col  = CW'(s_tdata[COL_LSB +: COL_W]);
	assign in_val  = s_tdata[VAL_LSB +: VAL_W];
	assign in_side = CW'(s_tdata[SIDE_LSB +: SIDE_W]);
	assign in_lvl  = floor_log2(s_tdata[SIDE_LSB +: SIDE_W]);

	// effective matrix side: 0 acts as 1, clamp to MAX_SIDE
	always_comb begin
		if (size_q == '0) begin
			n_eff = CW'(1);
		end else if (CW'(size_q) > CW'(MAX_SIDE)) begin
			n_eff = CW'(MAX_SIDE);
		end else begin
			n_eff = CW'(size_q);
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);

	// request decode
	logic in_fire, ld_ok, ld_build, q_fire, q_bad;
	assign in_fire  = s_tvalid && s_tready;
	assign ld_ok    = in_fire && (s_tuser[0] == REQ_LOAD) && (in_row < n_eff)
	                  && (in_col < n_eff);
	assign ld_build = ld_ok && (in_col == n_eff - CW'(1)) && (n_eff >= CW'(2));
	assign q_fire   = in_fire && (s_tuser[0] == REQ_QUERY);
	assign q_bad    = (in_side == '0) || (in_row + in_side > n_eff)
	                  || (in_col + in_side > n_eff) || (int'(in_lvl) >= LEVEL_COUNT);

	// build step decode
	logic [CW-1:0]    half, nlen;
	logic [LVL_W-1:0] nlvl;
	logic             bw_more, bw_next_lvl;
	assign half        = len_q >> 1;
	assign nlen        = len_q << 1;
	assign nlvl        = lvl_q + LVL_W'(1);
	assign bw_more     = (j_q + len_q + CW'(1) <= n_q);
	assign bw_next_lvl = (int'(nlvl) < LEVEL_COUNT) && (nlen <= n_q);

	// query step decode
	logic             q_last;
	logic [VAL_W-1:0] pair_max, best_next;
	assign q_last    = (row_q == last_row_q);
	assign pair_max  = (a_q > rdata_q) ? a_q : rdata_q;
	assign best_next = (pair_max > best_q) ? pair_max : best_q;

	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// table read port
	logic          re;
	logic [AW-1:0] raddr;
	always_comb begin
		re    = 1'b0;
		raddr = '0;
		case (state_q)
			ST_BA: begin
				re    = 1'b1;
				raddr = tbl_addr(row_q, lvl_q - LVL_W'(1), j_q);
			end
			ST_BB: begin
				re    = 1'b1;
				raddr = tbl_addr(row_q, lvl_q - LVL_W'(1), j_q + half);
			end
			ST_QA: begin
				re    = 1'b1;
				raddr = tbl_addr(row_q, lvl_q, col_q);
			end
			ST_QB: begin
				re    = 1'b1;
				raddr = tbl_addr(row_q, lvl_q, colb_q);
			end
			ST_QC: begin
				re    = !q_last;
				raddr = tbl_addr(row_q + CW'(1), lvl_q, col_q);
			end
			default: begin
				re    = 1'b0;
				raddr = '0;
			end
		endcase
	end

	// table write port: level 0 on load, built levels in ST_BW
	logic             we;
	logic [AW-1:0]    waddr;
	logic [VAL_W-1:0] wdata;
	always_comb begin
		if (state_q == ST_BW) begin
			we    = 1'b1;
			waddr = tbl_addr(row_q, lvl_q, j_q);
			wdata = pair_max;
		end else begin
			we    = ld_ok;
			waddr = tbl_addr(in_row, '0, in_col);
			wdata = in_val;
		end
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			tbl_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= tbl_q[raddr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			size_q     <= SIZE_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ld_build) begin
						state_q <= ST_BA;
					end else if (q_fire) begin
						state_q <= q_bad ? ST_DONE : ST_QA;
					end
				end
				ST_BA: state_q <= ST_BB;
				ST_BB: state_q <= ST_BW;
				ST_BW: begin
					state_q <= (bw_more || bw_next_lvl) ? ST_BA : ST_IDLE;
				end
				ST_QA: state_q <= ST_QB;
				ST_QB: state_q <= ST_QC;
				ST_QC: state_q <= q_last ? ST_DONE : ST_QB;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ld_build) begin
					row_q <= in_row;
					n_q   <= n_eff;
					lvl_q <= LVL_W'(1);
					len_q <= CW'(2);
					j_q   <= '0;
				end
				if (q_fire) begin
					row_q      <= in_row;
					last_row_q <= in_row + in_side - CW'(1);
					col_q      <= in_col;
					colb_q     <= in_col + in_side - (CW'(1) << in_lvl);
					lvl_q      <= in_lvl;
					best_q     <= '0;
					err_q      <= q_bad;
				end
			end
			ST_BB: a_q <= rdata_q;
			ST_BW: begin
				if (bw_more) begin
					j_q <= j_q + CW'(1);
				end else begin
					j_q   <= '0;
					lvl_q <= nlvl;
					len_q <= nlen;
				end
			end
			ST_QB: a_q <= rdata_q;
			ST_QC: begin
				best_q <= best_next;
				if (!q_last) begin
					row_q <= row_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_val_q <= best_q;
			m_err_q <= err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_val_q);
	assign m_tuser  = m_err_q;

endmodule

// ===== hw/rtl/srmst_chk.sv =====
module srmst_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [0:0]                       s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [srmst_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic [0:0]                       m_tuser
);
	import srmst_pkg::*;

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// an error result carries a zero maximum
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("error result with nonzero value");

	// an accepted query drops s_tready in the cycle after it
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == REQ_QUERY) |=> !s_tready)
		else $error("request taken right after a query");

endmodule

bind square_range_max_sparse_table srmst_chk u_srmst_chk (.*);
